// ----- rtl/core/sss_pkg.sv -----
// Package for the sync step sequencer: transaction payload types,
// operation, result-kind and register-index codes. No dependencies.

package sss_pkg;

  localparam int OP_W     = 2;
  localparam int ID_W     = 32;
  localparam int STEP_W   = 6;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_CNT_W = 7;
  localparam int EVENT_CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT      = 2'd0,
    OP_FRAME_END  = 2'd1,
    OP_TRIG_WRITE = 2'd2,
    OP_SCENE      = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STEP   = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT    = 2'd0,
    CFG_EVENT_COUNT   = 2'd1,
    CFG_SYNC_SENDER   = 2'd2,
    CFG_SYNC_FUNCTION = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   src_id;
    logic [ID_W-1:0]   src_func;
    logic [STEP_W-1:0] step_index;
    logic [SLOT_W-1:0] event_index;
    logic              trigger_value;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [STEP_W-1:0] step;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } out_item_t;

endpackage

// ----- rtl/core/sss_grid_mem.sv -----
// Trigger grid memory: one row per step, one write and one registered read
// port, per-row valid bits so that unwritten rows read as zero. No package.

module sss_grid_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [WIDTH-1:0] rd_raw_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw_r <= mem_r[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ----- rtl/core/sss_slot_scan.sv -----
// Slot scanner: finds the lowest set slot of a row and returns the row with
// that slot cleared. No package.

module sss_slot_scan #(
  parameter int WIDTH = 16,
  localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
  input  logic [WIDTH-1:0] row,
  output logic [IW-1:0]    slot,
  output logic [WIDTH-1:0] rest
);

  always_comb begin
    slot = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (row[i]) begin
        slot = IW'(i);
      end
    end
    rest = row & ~(WIDTH'(1) << slot);
  end

endmodule

// ----- rtl/core/sync_step_sequencer.sv -----
// Sync step sequencer top level: config registers, step state, sequencer,
// output register. Uses sss_pkg, sss_grid_mem and sss_slot_scan.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid, in_ready, in_data       | input transactions
//   out     | out_valid, out_ready, out_data    | result transactions
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata   | register writes
//
// Observed event, scene activation, unmatched frame end: handled in idle.
// Trigger write: a read-modify-write of one grid row in memory.
// Rejected write: a reject result. Frame end with advance: a step result,
// then one result per fired slot per cycle unless stalled (shared scanner).
// Stalls on out_ready hold the sequencer; in_ready is high only when idle.
// Reset is synchronous; grid rows read as zero until written.

module sync_step_sequencer
  import sss_pkg::*;
#(
  parameter int MAX_STEPS  = 64,
  parameter int MAX_EVENTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int EW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int SCW = $clog2(MAX_STEPS + 1);
  localparam int ECW = $clog2(MAX_EVENTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REPORT = 5'b00010,
    ST_FIRE   = 5'b00100,
    ST_REJECT = 5'b01000,
    ST_WRITE  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   step_count_r;
  logic [EVENT_CNT_W-1:0]  event_count_r;
  logic [ID_W-1:0]         sync_sender_r;
  logic [ID_W-1:0]         sync_function_r;
  logic [SW-1:0]           cur_step_r, cur_step_nxt;
  logic                    sync_seen_r, sync_seen_nxt;
  logic [MAX_EVENTS-1:0]   row_r, row_nxt;
  logic [SW-1:0]           wr_addr_r, wr_addr_nxt;
  logic [EW-1:0]           wr_bit_r, wr_bit_nxt;
  logic                    wr_val_r, wr_val_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic [SCW-1:0]          eff_steps;
  logic [ECW-1:0]          eff_events;
  logic [MAX_EVENTS-1:0]   ev_mask;
  logic [SW-1:0]           step_adv;
  logic                    in_fire;
  logic                    out_free;
  logic                    emit;
  logic                    wr_ok;
  logic                    mem_rd_en;
  logic [SW-1:0]           mem_rd_addr;
  logic [MAX_EVENTS-1:0]   mem_rd_data;
  logic                    mem_wr_en;
  logic [MAX_EVENTS-1:0]   mem_wr_data;
  logic [MAX_EVENTS-1:0]   row_masked;
  logic [EW-1:0]           scan_slot;
  logic [MAX_EVENTS-1:0]   scan_rest;

  sss_grid_mem #(
    .DEPTH (MAX_STEPS),
    .WIDTH (MAX_EVENTS)
  ) u_grid (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_addr_r),
    .wr_data (mem_wr_data)
  );

  sss_slot_scan #(
    .WIDTH (MAX_EVENTS)
  ) u_scan (
    .row  (row_r),
    .slot (scan_slot),
    .rest (scan_rest)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r    <= STEP_CNT_W'(1);
      event_count_r   <= '0;
      sync_sender_r   <= '0;
      sync_function_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_COUNT:    step_count_r    <= cfg_wdata[STEP_CNT_W-1:0];
        CFG_EVENT_COUNT:   event_count_r   <= cfg_wdata[EVENT_CNT_W-1:0];
        CFG_SYNC_SENDER:   sync_sender_r   <= cfg_wdata[ID_W-1:0];
        CFG_SYNC_FUNCTION: sync_function_r <= cfg_wdata[ID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(step_count_r) >= MAX_STEPS) begin
      eff_steps = SCW'(MAX_STEPS);
    end else if (step_count_r == '0) begin
      eff_steps = SCW'(1);
    end else begin
      eff_steps = SCW'(step_count_r);
    end
    if (int'(event_count_r) >= MAX_EVENTS) begin
      eff_events = ECW'(MAX_EVENTS);
    end else begin
      eff_events = ECW'(event_count_r);
    end
    for (int i = 0; i < MAX_EVENTS; i++) begin
      ev_mask[i] = (i < int'(eff_events));
    end
    if (int'(cur_step_r) + 1 >= int'(eff_steps)) begin
      step_adv = '0;
    end else begin
      step_adv = SW'(int'(cur_step_r) + 1);
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign wr_ok      = (int'(in_data.step_index) < int'(eff_steps)) &&
                      (int'(in_data.event_index) < int'(eff_events));
  assign row_masked = mem_rd_data & ev_mask;

  always_comb begin
    mem_wr_data = mem_rd_data;
    mem_wr_data[wr_bit_r] = wr_val_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_step_nxt  = cur_step_r;
    sync_seen_nxt = sync_seen_r;
    row_nxt       = row_r;
    wr_addr_nxt   = wr_addr_r;
    wr_bit_nxt    = wr_bit_r;
    wr_val_nxt    = wr_val_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = step_adv;
    mem_wr_en     = 1'b0;
    emit          = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.op)
            OP_EVENT: begin
              if (in_data.src_id == sync_sender_r &&
                  in_data.src_func == sync_function_r) begin
                sync_seen_nxt = 1'b1;
              end
            end
            OP_FRAME_END: begin
              if (sync_seen_r) begin
                sync_seen_nxt = 1'b0;
                cur_step_nxt  = step_adv;
                mem_rd_en     = 1'b1;
                state_nxt     = ST_REPORT;
              end
            end
            OP_TRIG_WRITE: begin
              if (wr_ok) begin
                wr_addr_nxt = SW'(in_data.step_index);
                wr_bit_nxt  = EW'(in_data.event_index);
                wr_val_nxt  = in_data.trigger_value;
                mem_rd_addr = SW'(in_data.step_index);
                mem_rd_en   = 1'b1;
                state_nxt   = ST_WRITE;
              end else begin
                state_nxt = ST_REJECT;
              end
            end
            OP_SCENE: cur_step_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = '{kind: KIND_STEP, step: STEP_W'(cur_step_r), slot: '0,
                           last: (row_masked == '0)};
          row_nxt      = row_masked;
          state_nxt    = (row_masked == '0) ? ST_IDLE : ST_FIRE;
        end
      end
      ST_FIRE: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = '{kind: KIND_FIRE, step: STEP_W'(cur_step_r),
                           slot: SLOT_W'(scan_slot), last: (scan_rest == '0)};
          row_nxt      = scan_rest;
          if (scan_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_data_nxt = '{kind: KIND_REJECT, step: STEP_W'(cur_step_r), slot: '0,
                           last: 1'b1};
          state_nxt    = ST_IDLE;
        end
      end
      ST_WRITE: begin
        mem_wr_en = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_step_r  <= '0;
      sync_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_step_r  <= cur_step_nxt;
      sync_seen_r <= sync_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_bit_r   <= wr_bit_nxt;
    wr_val_r   <= wr_val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_advance_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == OP_FRAME_END && sync_seen_r) |=> (state_r == ST_REPORT))
    else $error("frame end with armed sync did not start a report");

  a_fire_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIRE) |-> (row_r != '0))
    else $error("fire phase entered with an empty row");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_data_nxt.last) |=> (state_r == ST_IDLE && out_valid_r))
    else $error("last result did not return the sequencer to idle");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT) |-> (int'(cur_step_r) < int'(eff_steps)))
    else $error("advanced step outside the effective step count");
`endif

endmodule
